// ----- design/lecs_pkg.sv -----
// ----------------------------------------------------------------------------
// lecs_pkg
// Shared types and constants of the level envelope command sequencer.
// ----------------------------------------------------------------------------
package lecs_pkg;

  localparam int MAX_CMDS = 16;
  localparam int IDX_W    = $clog2(MAX_CMDS);
  localparam int CNT_W    = $clog2(MAX_CMDS + 1);

  localparam int DUR_W    = 28;
  localparam int LVL_W    = 16;
  localparam int FRAC_W   = 17;

  localparam logic [LVL_W-1:0]  UNITY   = 16'h8000;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [DUR_W-1:0]  CAP28   = 28'hFFFFFFF;

  // input opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  // entry kinds
  localparam logic [2:0] K_PLAY  = 3'd0;
  localparam logic [2:0] K_STOP  = 3'd1;
  localparam logic [2:0] K_LEVEL = 3'd2;
  localparam logic [2:0] K_WAIT  = 3'd3;
  localparam logic [2:0] K_RAMP  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_LOOP  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_RATE  = 2'd2;

  typedef struct packed {
    logic        curve;
    logic [19:0] dur;
    logic [15:0] level;
    logic [2:0]  kind;
  } cmd_entry_t;

endpackage

// ----- design/level_envelope_command_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// level_envelope_command_sequencer_unit
// Plays a 16-entry table of level commands, paced by sample ticks.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  in      | in_valid/in_ready, opcode, entry_* | input
//  out     | out_valid/out_ready, level, flags  | output
//  cfg     | cfg_valid/cfg_ready, index, data   | input
//
//  A ramp tick runs the shared divider loop and, for an equal power curve,
//  the root loop; the divider is skipped once the ramp has reached its end.
//  Start and tick completions walk the table entry by entry, then wrap,
//  stop or set up the next timed command.
//  Reset is synchronous; the table holds no reset value.
//  in_ready drops while one beat is in work; a stalled result holds in the
//  output register and the next beat is still taken.
// ----------------------------------------------------------------------------
module level_envelope_command_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_entry_index,
  input  logic [2:0]  in_entry_kind,
  input  logic [15:0] in_entry_level,
  input  logic [19:0] in_entry_duration,
  input  logic        in_entry_curve,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_level,
  output logic        out_playback_enabled,
  output logic        out_sequence_running,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [18:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_BEGIN, S_DIV, S_FUNC, S_SQRT, S_SCALE, S_CHECK, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic                          loop_r;
  logic [4:0]                    count_r;
  logic [18:0]                   rate_r;

  // sequencer state
  logic [lecs_pkg::CNT_W-1:0]    step_r;
  logic [lecs_pkg::CNT_W-1:0]    visited_r;
  logic [lecs_pkg::DUR_W-1:0]    elapsed_r;
  logic [lecs_pkg::DUR_W-1:0]    dur_r;
  logic [lecs_pkg::LVL_W-1:0]    start_lvl_r;
  logic [lecs_pkg::LVL_W-1:0]    level_r;
  logic                          play_r;
  logic                          running_r;
  logic                          timed_r;

  // shared arithmetic
  logic [4:0]                    cnt_r;
  logic [lecs_pkg::DUR_W-1:0]    rem_r;
  logic [15:0]                   quo_r;
  logic [32:0]                   sq_v_r;
  logic [32:0]                   sq_r_r;
  logic [32:0]                   sq_bit_r;
  logic [lecs_pkg::FRAC_W-1:0]   frac_r;

  // output register
  logic                          out_valid_r;
  logic [lecs_pkg::LVL_W-1:0]    out_level_r;
  logic                          out_play_r;
  logic                          out_run_r;

  lecs_pkg::cmd_entry_t          cmd_mem [lecs_pkg::MAX_CMDS];
  lecs_pkg::cmd_entry_t          cur_e;
  logic                          in_acc;
  logic [lecs_pkg::CNT_W-1:0]    eff_n;
  logic [lecs_pkg::CNT_W-1:0]    max_n;
  logic [lecs_pkg::DUR_W-1:0]    elapsed_inc;
  logic [38:0]                   dur_prod;
  logic [lecs_pkg::DUR_W:0]      div_t;
  logic                          div_ge;
  logic [lecs_pkg::DUR_W-1:0]    rem_nxt;
  logic [15:0]                   quo_nxt;
  logic [32:0]                   sq_sum;
  logic                          sq_ge;
  logic [32:0]                   sq_r_nxt;
  logic                          rising;
  logic [lecs_pkg::LVL_W-1:0]    span;
  logic [32:0]                   scaled;
  logic                          out_free;

  assign max_n    = lecs_pkg::CNT_W'(lecs_pkg::MAX_CMDS);
  assign eff_n    = (lecs_pkg::CNT_W'(count_r) > max_n || count_r > 5'(lecs_pkg::MAX_CMDS))
                    ? max_n : lecs_pkg::CNT_W'(count_r);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // entry at the current step; out of range reads as an empty entry
  assign cur_e = (step_r >= max_n) ? '0 : cmd_mem[step_r[lecs_pkg::IDX_W-1:0]];

  assign elapsed_inc = (elapsed_r < lecs_pkg::CAP28) ? elapsed_r + 1'b1 : elapsed_r;
  assign dur_prod    = 39'(cur_e.dur) * 39'(rate_r);

  // one restoring divider step
  assign div_t   = {rem_r, 1'b0};
  assign div_ge  = div_t >= {1'b0, dur_r};
  assign rem_nxt = div_ge ? lecs_pkg::DUR_W'(div_t - {1'b0, dur_r}) : div_t[lecs_pkg::DUR_W-1:0];
  assign quo_nxt = {quo_r[14:0], div_ge};

  // one square root step
  assign sq_sum   = sq_r_r + sq_bit_r;
  assign sq_ge    = sq_v_r >= sq_sum;
  assign sq_r_nxt = sq_ge ? (sq_r_r >> 1) + sq_bit_r : (sq_r_r >> 1);

  assign rising = cur_e.level > start_lvl_r;
  assign span   = (cur_e.level >= start_lvl_r) ? cur_e.level - start_lvl_r
                                               : start_lvl_r - cur_e.level;
  assign scaled = 33'(span) * 33'(frac_r);

  assign out_free = !out_valid_r || out_ready;

  // command table: write on an accepted write-entry beat
  always_ff @(posedge clk) begin
    if (in_acc && in_opcode == lecs_pkg::OP_WRITE &&
        lecs_pkg::CNT_W'(in_entry_index) < max_n) begin
      cmd_mem[lecs_pkg::IDX_W'(in_entry_index)] <= {in_entry_curve, in_entry_duration,
                                                   in_entry_level, in_entry_kind};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loop_r      <= 1'b0;
      count_r     <= '0;
      rate_r      <= 19'd48000;
      step_r      <= '0;
      visited_r   <= '0;
      elapsed_r   <= '0;
      dur_r       <= '0;
      start_lvl_r <= '0;
      level_r     <= lecs_pkg::UNITY;
      play_r      <= 1'b0;
      running_r   <= 1'b0;
      timed_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lecs_pkg::CFG_LOOP:  loop_r  <= cfg_data[0];
          lecs_pkg::CFG_COUNT: count_r <= cfg_data[4:0];
          lecs_pkg::CFG_RATE:  rate_r  <= cfg_data;
          default: ;
        endcase
      end

      // drop the result once taken, unless a new one loads this cycle
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_opcode)
              lecs_pkg::OP_START: begin
                step_r      <= '0;
                visited_r   <= '0;
                elapsed_r   <= '0;
                dur_r       <= '0;
                timed_r     <= 1'b0;
                start_lvl_r <= level_r;
                play_r      <= 1'b0;
                level_r     <= lecs_pkg::UNITY;
                running_r   <= 1'b1;
                state_r     <= S_WALK;
              end
              lecs_pkg::OP_CANCEL: begin
                running_r <= 1'b0;
                play_r    <= 1'b0;
                level_r   <= lecs_pkg::UNITY;
                step_r    <= '0;
                elapsed_r <= '0;
                dur_r     <= '0;
                timed_r   <= 1'b0;
                state_r   <= S_DONE;
              end
              lecs_pkg::OP_TICK: begin
                if (running_r && timed_r) begin
                  elapsed_r <= elapsed_inc;
                  if (cur_e.kind == lecs_pkg::K_RAMP) begin
                    rem_r   <= elapsed_inc;
                    quo_r   <= '0;
                    cnt_r   <= '0;
                    state_r <= S_DIV;
                  end else begin
                    state_r <= S_CHECK;
                  end
                end else begin
                  state_r <= S_DONE;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end

        // run immediate commands up to the next timed one, wrapping or stopping at the table end
        S_WALK: begin
          if (step_r >= eff_n) begin
            if (!loop_r) begin
              running_r <= 1'b0;
              state_r   <= S_DONE;
            end else if (eff_n == '0) begin
              state_r <= S_DONE;
            end else begin
              step_r <= '0;
            end
          end else if (visited_r >= eff_n) begin
            step_r  <= eff_n;
            state_r <= S_DONE;
          end else if (cur_e.kind == lecs_pkg::K_WAIT || cur_e.kind == lecs_pkg::K_RAMP) begin
            state_r <= S_BEGIN;
          end else begin
            case (cur_e.kind)
              lecs_pkg::K_PLAY:  play_r  <= 1'b1;
              lecs_pkg::K_STOP:  play_r  <= 1'b0;
              lecs_pkg::K_LEVEL: level_r <= cur_e.level;
              default: ;
            endcase
            step_r    <= step_r + 1'b1;
            visited_r <= visited_r + 1'b1;
          end
        end

        // set up a timed command: samples = dur * rate >> 10, saturated
        S_BEGIN: begin
          elapsed_r <= '0;
          dur_r     <= dur_prod[38] ? lecs_pkg::CAP28 : dur_prod[37:10];
          timed_r   <= 1'b1;
          if (cur_e.kind == lecs_pkg::K_RAMP) start_lvl_r <= level_r;
          state_r   <= S_DONE;
        end

        // p = elapsed * 65536 / duration, one quotient bit per cycle
        S_DIV: begin
          if (cnt_r == '0 && elapsed_r >= dur_r) begin
            frac_r  <= lecs_pkg::ONE_Q16;
            state_r <= S_FUNC;
          end else begin
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == 5'd15) begin
              frac_r  <= {1'b0, quo_nxt};
              state_r <= S_FUNC;
            end
          end
        end

        S_FUNC: begin
          if (!cur_e.curve) begin
            state_r <= S_SCALE;
          end else begin
            sq_v_r   <= rising ? {frac_r, 16'h0} : {lecs_pkg::ONE_Q16 - frac_r, 16'h0};
            sq_r_r   <= '0;
            sq_bit_r <= 33'h1_0000_0000;
            cnt_r    <= '0;
            state_r  <= S_SQRT;
          end
        end

        // integer square root, one result bit per cycle
        S_SQRT: begin
          if (sq_ge) sq_v_r <= sq_v_r - sq_sum;
          sq_r_r   <= sq_r_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == 5'd16) begin
            frac_r  <= rising ? sq_r_nxt[lecs_pkg::FRAC_W-1:0]
                              : lecs_pkg::ONE_Q16 - sq_r_nxt[lecs_pkg::FRAC_W-1:0];
            state_r <= S_SCALE;
          end
        end

        S_SCALE: begin
          if (cur_e.level >= start_lvl_r) level_r <= start_lvl_r + scaled[31:16];
          else                            level_r <= start_lvl_r - scaled[31:16];
          state_r <= S_CHECK;
        end

        // advance past a finished timed command
        S_CHECK: begin
          if (elapsed_r >= dur_r) begin
            step_r    <= step_r + 1'b1;
            visited_r <= '0;
            elapsed_r <= '0;
            dur_r     <= '0;
            timed_r   <= 1'b0;
            state_r   <= S_WALK;
          end else begin
            state_r <= S_DONE;
          end
        end

        // hold until the output register is free
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_level_r <= level_r;
            out_play_r  <= play_r;
            out_run_r   <= running_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_level            = out_level_r;
  assign out_playback_enabled = out_play_r;
  assign out_sequence_running = out_run_r;

  a_timed_running: assert property (@(posedge clk) disable iff (!rst_n)
    timed_r |-> running_r) else $error("timed command without running sequence");

  a_timed_step: assert property (@(posedge clk) disable iff (!rst_n)
    timed_r |-> step_r < max_n) else $error("timed command past table end");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> cnt_r <= 5'd16) else $error("root loop overrun");

  a_div_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> timed_r && cur_e.kind == lecs_pkg::K_RAMP)
    else $error("divider started outside a ramp");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives level commands, table writes and register settings into the level
// envelope command sequencer. A tracker class mirrors the table walk, the
// timing and the ramp arithmetic, and checks every result beat in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  CYCLE_LIMIT = 3_000_000;
  localparam int  DRAIN_WAIT  = 100;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  index;
    logic [2:0]  kind;
    logic [15:0] level;
    logic [19:0] dur;
    logic        curve;
  } command_beat_t;

  typedef struct packed {
    logic [15:0] level;
    logic        playback;
    logic        running;
  } level_state_t;

  // --------------------------------------------------------------------------
  // Envelope tracker: its own copy of table, registers and sequencer state.
  // --------------------------------------------------------------------------
  class envelope_tracker;
    lecs_pkg::cmd_entry_t table_mem[lecs_pkg::MAX_CMDS];
    int unsigned     step;
    int unsigned     elapsed;
    int unsigned     duration;
    logic [15:0]     ramp_from;
    logic [15:0]     cur_level;
    bit              playback;
    bit              running;
    bit              timed_on;
    bit              loop_on;
    int unsigned     count_reg;
    int unsigned     rate_reg;
    level_state_t    expected_levels[$];
    int              errors;

    function new();
      step = 0; elapsed = 0; duration = 0; ramp_from = 0;
      cur_level = lecs_pkg::UNITY; playback = 0; running = 0; timed_on = 0;
      loop_on = 0; count_reg = 0; rate_reg = 48000; errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [18:0] data);
      if (idx == lecs_pkg::CFG_LOOP) loop_on = data[0];
      else if (idx == lecs_pkg::CFG_COUNT) count_reg = 32'(data[4:0]);
      else if (idx == lecs_pkg::CFG_RATE) rate_reg = 32'(data);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void start_timed(lecs_pkg::cmd_entry_t e);
      longint unsigned d = (longint'(e.dur) * longint'(rate_reg)) >> 10;
      elapsed  = 0;
      duration = (d > lecs_pkg::CAP28) ? 32'(lecs_pkg::CAP28) : 32'(d);
      timed_on = 1;
      if (e.kind == lecs_pkg::K_RAMP) ramp_from = cur_level;
    endfunction

    // Run immediate commands until a timed one or the end of the table.
    function void walk_table();
      int unsigned n = (count_reg > lecs_pkg::MAX_CMDS) ? lecs_pkg::MAX_CMDS : count_reg;
      int unsigned visited = 0;
      lecs_pkg::cmd_entry_t e;
      while (1) begin
        if (step >= n) begin
          if (!loop_on) begin
            running = 0;
            return;
          end
          if (n == 0) return;
          step = 0;
        end
        if (visited >= n) begin
          step = n;
          return;
        end
        e = (step < lecs_pkg::MAX_CMDS) ? table_mem[step] : '0;
        if (e.kind == lecs_pkg::K_WAIT || e.kind == lecs_pkg::K_RAMP) begin
          start_timed(e);
          return;
        end
        if (e.kind == lecs_pkg::K_PLAY) playback = 1;
        else if (e.kind == lecs_pkg::K_STOP) playback = 0;
        else if (e.kind == lecs_pkg::K_LEVEL) cur_level = e.level;
        step++;
        visited++;
      end
    endfunction

    function void ramp_level(lecs_pkg::cmd_entry_t e);
      longint unsigned p, f, span;
      int unsigned     target = 32'(e.level);
      int unsigned     from   = 32'(ramp_from);
      if (duration == 0) p = lecs_pkg::ONE_Q16;
      else begin
        p = (longint'(elapsed) << 16) / duration;
        if (p > lecs_pkg::ONE_Q16) p = lecs_pkg::ONE_Q16;
      end
      if (!e.curve) f = p;
      else if (target > from) f = int_sqrt(p << 16);
      else f = lecs_pkg::ONE_Q16 - int_sqrt((lecs_pkg::ONE_Q16 - p) << 16);
      if (target >= from) begin
        span = target - from;
        cur_level = 16'(from + ((span * f) >> 16));
      end else begin
        span = from - target;
        cur_level = 16'(from - ((span * f) >> 16));
      end
    endfunction

    function void clear_run();
      running = 0; playback = 0; cur_level = lecs_pkg::UNITY;
      step = 0; elapsed = 0; duration = 0; timed_on = 0;
    endfunction

    function void accept_command(command_beat_t c);
      lecs_pkg::cmd_entry_t e;
      if (c.opcode == lecs_pkg::OP_WRITE) begin
        table_mem[c.index] = '{curve: c.curve, dur: c.dur, level: c.level, kind: c.kind};
      end else if (c.opcode == lecs_pkg::OP_START) begin
        step = 0; elapsed = 0; duration = 0; timed_on = 0;
        ramp_from = cur_level; playback = 0; cur_level = lecs_pkg::UNITY; running = 1;
        walk_table();
      end else if (c.opcode == lecs_pkg::OP_CANCEL) begin
        clear_run();
      end else if (running && timed_on) begin
        e = (step < lecs_pkg::MAX_CMDS) ? table_mem[step] : '0;
        if (elapsed < lecs_pkg::CAP28) elapsed++;
        if (e.kind == lecs_pkg::K_RAMP) ramp_level(e);
        if (elapsed >= duration) begin
          step++; elapsed = 0; duration = 0; timed_on = 0;
          walk_table();
        end
      end
      expected_levels.push_back('{level: cur_level, playback: playback, running: running});
    endfunction

    function void check_level_beat(level_state_t got);
      level_state_t want;
      if (expected_levels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = expected_levels.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch at %0t: level exp %0d got %0d, ",
                    "play exp %0b got %0b, run exp %0b got %0b"},
                   $time, want.level, got.level, want.playback, got.playback,
                   want.running, got.running);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_opcode = lecs_pkg::OP_TICK;
  logic [3:0]  in_entry_index = 0;
  logic [2:0]  in_entry_kind = lecs_pkg::K_PLAY;
  logic [15:0] in_entry_level = 0;
  logic [19:0] in_entry_duration = 0;
  logic        in_entry_curve = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] out_level;
  logic        out_playback_enabled;
  logic        out_sequence_running;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = lecs_pkg::CFG_LOOP;
  logic [18:0] cfg_data = 0;

  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     cycles = 0;
  envelope_tracker tracker = new();

  initial begin
    forever #5 clk = ~clk;
  end

  level_envelope_command_sequencer_unit u_dut (.*);

  // Receiver: stall at the configured rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: note accepted beats first, then check results of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        tracker.accept_command('{opcode: in_opcode, index: in_entry_index,
                                 kind: in_entry_kind, level: in_entry_level,
                                 dur: in_entry_duration, curve: in_entry_curve});
      if (out_valid && out_ready)
        tracker.check_level_beat('{level: out_level, playback: out_playback_enabled,
                                   running: out_sequence_running});
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Hold valid across back-to-back beats; drop it only for an idle gap.
  task automatic send_command(command_beat_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid          <= 1;
    in_opcode         <= c.opcode;
    in_entry_index    <= c.index;
    in_entry_kind     <= c.kind;
    in_entry_level    <= c.level;
    in_entry_duration <= c.dur;
    in_entry_curve    <= c.curve;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_op(logic [1:0] op);
    command_beat_t c;
    c = '0;
    c.opcode = op;
    c.level  = 16'($urandom);
    c.dur    = 20'($urandom);
    send_command(c);
  endtask

  task automatic send_entry(logic [3:0] idx, logic [2:0] kind, logic [15:0] lvl,
                            logic [19:0] dur, logic curve);
    send_command('{opcode: lecs_pkg::OP_WRITE, index: idx, kind: kind, level: lvl,
                   dur: dur, curve: curve});
  endtask

  // Drain the pipe, then write one register while the block is idle.
  task automatic write_register(logic [1:0] idx, logic [18:0] data);
    in_valid <= 0;
    @(posedge clk);
    while (tracker.expected_levels.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    cfg_valid <= 0;
  endtask

  // Random beat: mostly ticks inside running sequences, with table edits,
  // restarts and cancels mixed in.
  function automatic command_beat_t random_command();
    command_beat_t c;
    int unsigned   pick = $urandom_range(99);
    c = '0;
    c.index = 4'($urandom);
    c.level = 16'($urandom);
    c.curve = 1'($urandom);
    c.kind  = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    c.dur   = ($urandom_range(19) == 0) ? 20'($urandom) : 20'($urandom_range(3));
    if (pick < 68) c.opcode = lecs_pkg::OP_TICK;
    else if (pick < 86) c.opcode = lecs_pkg::OP_WRITE;
    else if (pick < 96) c.opcode = lecs_pkg::OP_START;
    else c.opcode = lecs_pkg::OP_CANCEL;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  typedef struct {
    bit          loop_on;
    int unsigned count;
    int unsigned rate;
  } run_setting_t;

  run_setting_t settings[8] = '{
    '{1, 16, 1}, '{0, 4, 384000}, '{1, 3, 1000}, '{0, 16, 50},
    '{1, 0, 48000}, '{0, 0, 48000}, '{1, 8, 300}, '{0, 12, 2}
  };

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Fill every slot so no read ever hits an unwritten entry; cover the
    // field extremes, both curves and the do-nothing kinds.
    send_entry(0,  lecs_pkg::K_PLAY,  16'h0000, 20'h00000, 0);
    send_entry(1,  lecs_pkg::K_RAMP,  16'hFFFF, 20'h00000, 1);
    send_entry(2,  lecs_pkg::K_LEVEL, 16'hFFFF, 20'hFFFFF, 1);
    send_entry(3,  lecs_pkg::K_RAMP,  16'h0000, 20'h00001, 1);
    send_entry(4,  lecs_pkg::K_WAIT,  16'h1234, 20'h00000, 0);
    send_entry(5,  lecs_pkg::K_STOP,  16'h8000, 20'h00002, 0);
    send_entry(6,  3'd5,              16'h5555, 20'h55555, 1);
    send_entry(7,  3'd6,              16'hAAAA, 20'hAAAAA, 0);
    send_entry(8,  3'd7,              16'h7FFF, 20'h00003, 1);
    send_entry(9,  lecs_pkg::K_RAMP,  16'h4000, 20'h00002, 0);
    send_entry(10, lecs_pkg::K_WAIT,  16'h0001, 20'hFFFFF, 1);
    send_entry(11, lecs_pkg::K_RAMP,  16'hC000, 20'h00001, 0);
    send_entry(12, lecs_pkg::K_LEVEL, 16'h0000, 20'h00000, 0);
    send_entry(13, lecs_pkg::K_RAMP,  16'h8000, 20'h00003, 1);
    send_entry(14, lecs_pkg::K_PLAY,  16'hFFFF, 20'h00001, 1);
    send_entry(15, lecs_pkg::K_WAIT,  16'h0000, 20'h00001, 0);
    // Empty table without loop stops at once; tick while stopped; cancel.
    send_op(lecs_pkg::OP_START);
    send_op(lecs_pkg::OP_TICK);
    send_op(lecs_pkg::OP_CANCEL);
    send_op(lecs_pkg::OP_TICK);

    foreach (settings[i]) begin
      write_register(lecs_pkg::CFG_LOOP,  19'(settings[i].loop_on));
      write_register(lecs_pkg::CFG_COUNT, 19'(settings[i].count));
      write_register(lecs_pkg::CFG_RATE,  19'(settings[i].rate));
      case (i % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      send_op(lecs_pkg::OP_START);
      repeat (150) send_command(random_command());
    end

    // Drain and settle.
    in_valid <= 0;
    @(posedge clk);
    while (tracker.expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
